FILE: hdl/ssc_pkg.sv
// Shared constants and types for the subset-sum counter.
`default_nettype none

package ssc_pkg;

    // Default sizing of the count row.
    localparam int DEF_MAX_SUM    = 1023;
    localparam int DEF_COUNT_BITS = 32;

    // Fixed field widths.
    localparam int TARGET_W = 10;
    localparam int ELEM_W   = 16;
    localparam int OUT_W    = 32;

    // Per-item flags handed from the front to the back through the queue.
    typedef struct packed {
        logic skip;   // element exceeds the target, row update is skipped
        logic last;   // final element of the set, result follows
    } ssc_flags_t;

    localparam int FLAGS_W = $bits(ssc_flags_t);

endpackage : ssc_pkg

`default_nettype wire

FILE: hdl/ssc_front.sv
// Front end: target register, input handshake and element classification.
`default_nettype none

module ssc_front
    import ssc_pkg::*;
#(
    parameter int MAX_SUM = DEF_MAX_SUM,
    localparam int IDX_W  = $clog2(MAX_SUM + 1)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [TARGET_W-1:0] cfg_data,
    // element stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [ELEM_W-1:0]   s_tdata,
    input  wire logic                s_tlast,
    // back end is sweeping the row
    input  wire logic                hold,
    // queue push side
    output logic                     push_valid,
    input  wire logic                push_ready,
    output logic [IDX_W-1:0]         push_elem,
    output logic [IDX_W-1:0]         push_tgt,
    output ssc_flags_t               push_flags
);

    logic [TARGET_W-1:0] target_reg;
    logic [IDX_W-1:0]    eff_tgt;
    logic                tgt_clamp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            target_reg <= cfg_data;
        end
    end

    // Targets beyond the row are clamped to the last entry.
    assign tgt_clamp = (32'(target_reg) > 32'(MAX_SUM));
    assign eff_tgt   = tgt_clamp ? IDX_W'(MAX_SUM) : IDX_W'(target_reg);

    assign s_tready   = push_ready && !hold;
    assign push_valid = s_tvalid && s_tready;

    // Element index is only meaningful when the element fits under the target.
    assign push_elem       = IDX_W'(s_tdata);
    assign push_tgt        = eff_tgt;
    assign push_flags.skip = (32'(s_tdata) > 32'(eff_tgt));
    assign push_flags.last = s_tlast;

endmodule : ssc_front

`default_nettype wire

FILE: hdl/ssc_queue.sv
// Two-entry queue between the front end and the row sequencer.
`default_nettype none

module ssc_queue
    import ssc_pkg::*;
#(
    parameter int WIDTH = 2 * ELEM_W + FLAGS_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule : ssc_queue

`default_nettype wire

FILE: hdl/ssc_back.sv
// Back end: count-row memory, update sequencer, clearing sweep and result register.
`default_nettype none

module ssc_back
    import ssc_pkg::*;
#(
    parameter int MAX_SUM    = DEF_MAX_SUM,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    localparam int IDX_W     = $clog2(MAX_SUM + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // queue pop side
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire logic [IDX_W-1:0] q_elem,
    input  wire logic [IDX_W-1:0] q_tgt,
    input  wire ssc_flags_t       q_flags,
    // row sweep in progress
    output logic                  clearing,
    // result stream
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tuser
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_SETTLE,
        ST_RES_RD,
        ST_RES_WAIT
    } state_t;

    state_t                 state_reg;
    logic [IDX_W-1:0]       j_reg;
    logic [IDX_W-1:0]       a_reg;
    logic [IDX_W-1:0]       tgt_reg;
    logic                   last_reg;
    logic [IDX_W-1:0]       clr_idx_reg;
    logic                   pend_reg;
    logic [IDX_W-1:0]       pend_addr_reg;
    logic                   ovf_reg;
    logic                   m_valid_reg;
    logic [OUT_W-1:0]       m_data_reg;
    logic                   m_sat_reg;

    logic [COUNT_BITS-1:0]  mem [0:MAX_SUM];
    logic [COUNT_BITS-1:0]  rd_a_reg;
    logic [COUNT_BITS-1:0]  rd_b_reg;

    logic [COUNT_BITS:0]    sum_wide;
    logic                   carry;
    logic [COUNT_BITS-1:0]  sum_sat;
    logic                   we;
    logic [IDX_W-1:0]       waddr;
    logic [COUNT_BITS-1:0]  wdata;
    logic                   rd_a_en;
    logic                   rd_b_en;
    logic [IDX_W-1:0]       addr_a;
    logic [IDX_W-1:0]       addr_b;
    logic                   out_free;
    logic [63:0]            c_ext;
    logic                   c_hi;
    logic [OUT_W-1:0]       res_cnt;
    logic                   res_sat;

    // Saturating add of the two registered reads.
    assign sum_wide = {1'b0, rd_a_reg} + {1'b0, rd_b_reg};
    assign carry    = sum_wide[COUNT_BITS];
    assign sum_sat  = carry ? '1 : sum_wide[COUNT_BITS-1:0];

    assign clearing = (state_reg == ST_CLEAR);

    // Write port: sweep writes the starting row, otherwise the pending update.
    assign we    = clearing || pend_reg;
    assign waddr = clearing ? clr_idx_reg : pend_addr_reg;
    assign wdata = clearing ? ((clr_idx_reg == '0) ? COUNT_BITS'(1) : '0) : sum_sat;

    // Read ports: A reads count[j] or count[target], B reads count[j-a].
    assign rd_a_en = (state_reg == ST_RUN) || (state_reg == ST_RES_RD);
    assign rd_b_en = (state_reg == ST_RUN);
    assign addr_a  = (state_reg == ST_RUN) ? j_reg : tgt_reg;
    assign addr_b  = j_reg - a_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_a_en) begin
            rd_a_reg <= mem[addr_a];
        end
        if (rd_b_en) begin
            rd_b_reg <= mem[addr_b];
        end
    end

    // Result formatting: counts beyond the output field clamp and flag.
    assign c_ext   = 64'(rd_a_reg);
    assign c_hi    = |c_ext[63:32];
    assign res_cnt = c_hi ? '1 : c_ext[31:0];
    assign res_sat = c_hi || ovf_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign q_ready  = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= IDX_W'(MAX_SUM);
            pend_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            pend_reg <= 1'b0;
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (pend_reg && carry) begin
                ovf_reg <= 1'b1;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    if (clr_idx_reg == '0) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        clr_idx_reg <= clr_idx_reg - IDX_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        tgt_reg  <= q_tgt;
                        a_reg    <= q_elem;
                        j_reg    <= q_tgt;
                        last_reg <= q_flags.last;
                        if (!q_flags.skip) begin
                            state_reg <= ST_RUN;
                        end else if (q_flags.last) begin
                            state_reg <= ST_RES_RD;
                        end
                    end
                end
                ST_RUN: begin
                    pend_reg      <= 1'b1;
                    pend_addr_reg <= j_reg;
                    if (j_reg == a_reg) begin
                        state_reg <= ST_SETTLE;
                    end else begin
                        j_reg <= j_reg - IDX_W'(1);
                    end
                end
                ST_SETTLE: begin
                    // last write of the pass lands this cycle
                    state_reg <= last_reg ? ST_RES_RD : ST_IDLE;
                end
                ST_RES_RD: begin
                    state_reg <= ST_RES_WAIT;
                end
                ST_RES_WAIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_cnt;
                        m_sat_reg   <= res_sat;
                        ovf_reg     <= 1'b0;
                        clr_idx_reg <= IDX_W'(MAX_SUM);
                        state_reg   <= ST_CLEAR;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;

endmodule : ssc_back

`default_nettype wire

FILE: hdl/subset_sum_count_rolling.sv
// Top level of the rolling one-row subset-sum counter.
//
//  Channel   Dir  Handshake               Payload
//  --------  ---  ----------------------  -------------------------------------------
//  cfg       in   cfg_valid / cfg_ready   cfg_data[9:0]  = target_sum
//  s_        in   s_tvalid  / s_tready    s_tdata[15:0]  = element_value,
//                                         s_tlast        = last_element
//  m_        out  m_tvalid  / m_tready    m_tdata[31:0]  = subset_count,
//                                         m_tuser[0]     = saturated
//
// Row walk: an element a <= t (t = target clamped to MAX_SUM) walks the row from t down
//   to a, one row entry per cycle (two read ports, one write port); above t, it skips the row.
//   A last element adds the result read, then a sweep that rewrites all MAX_SUM + 1 entries.
// Reset: synchronous, active low; the same sweep runs after release, s_tready held low.
// Stalls: a two-entry queue parts the front from the back; a held result in the output
//   register only blocks the back at the next set's result.
`default_nettype none

module subset_sum_count_rolling
    import ssc_pkg::*;
#(
    parameter int MAX_SUM    = DEF_MAX_SUM,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration write
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [TARGET_W-1:0] cfg_data,   // [9:0] target_sum
    // element stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [ELEM_W-1:0]   s_tdata,    // [15:0] element_value
    input  wire logic                s_tlast,
    // result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [OUT_W-1:0]         m_tdata,    // [31:0] subset_count
    output logic [0:0]               m_tuser     // [0] saturated
);

    localparam int IDX_W = $clog2(MAX_SUM + 1);
    localparam int Q_W   = 2 * IDX_W + FLAGS_W;

    logic             hold;
    logic             push_valid;
    logic             push_ready;
    logic [IDX_W-1:0] push_elem;
    logic [IDX_W-1:0] push_tgt;
    ssc_flags_t       push_flags;

    logic             pop_valid;
    logic             pop_ready;
    logic [Q_W-1:0]   pop_data;
    logic [IDX_W-1:0] pop_elem;
    logic [IDX_W-1:0] pop_tgt;
    ssc_flags_t       pop_flags;
    logic             sat_bit;

    // Front: holds the target, takes elements and flags the ones that skip the row.
    ssc_front #(
        .MAX_SUM (MAX_SUM)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .hold       (hold),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_elem  (push_elem),
        .push_tgt   (push_tgt),
        .push_flags (push_flags)
    );

    // Queue word: flags on top, then target, then element index.
    ssc_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   ({push_flags, push_tgt, push_elem}),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    assign pop_elem  = pop_data[IDX_W-1:0];
    assign pop_tgt   = pop_data[2*IDX_W-1:IDX_W];
    assign pop_flags = ssc_flags_t'(pop_data[Q_W-1:2*IDX_W]);

    // Back: walks the row from the target down, one entry per cycle.
    ssc_back #(
        .MAX_SUM    (MAX_SUM),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (pop_valid),
        .q_ready  (pop_ready),
        .q_elem   (pop_elem),
        .q_tgt    (pop_tgt),
        .q_flags  (pop_flags),
        .clearing (hold),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (sat_bit)
    );

    assign m_tuser = sat_bit;

endmodule : subset_sum_count_rolling

`default_nettype wire

FILE: hdl/ssc_checker.sv
// Port-level checks for the subset-sum counter, bound to the top level.
`default_nettype none

module ssc_checker
    import ssc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tready,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [OUT_W-1:0]    m_tdata,
    input  wire logic [0:0]          m_tuser
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // The row sweep after reset keeps the element channel closed.
    a_rst_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("element taken during the reset sweep");

    // A new result starts the row sweep, so no element is taken alongside it.
    a_res_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !s_tready)
        else $error("element taken while the row is being restored");

endmodule : ssc_checker

bind subset_sum_count_rolling ssc_checker u_ssc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

`default_nettype wire
